// File: src/ccrc_pkg.sv
// Shared types and constants for the configurable CRC engine.
package ccrc_pkg;

  localparam int CRC_W   = 32;
  localparam int DATA_W  = 8;
  localparam int CNT_W   = 4;
  localparam int DEG_W   = 5;
  localparam int NIBBLE  = 4;
  localparam int ADDR_W  = 4;
  localparam int IN_TDATA_W = 16;

  localparam logic [DEG_W-1:0] DEGREE_RESET = DEG_W'(16);

  typedef enum logic [1:0] {
    REG_POLY   = 2'd0,
    REG_DEGREE = 2'd1,
    REG_INIT   = 2'd2,
    REG_PAD    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CRC_W-1:0] poly;
    logic [CRC_W-1:0] init_value;
    logic [CRC_W-1:0] top_mask;
    logic [CRC_W-1:0] out_mask;
    logic             pad_to_nibble;
  } ccrc_cfg_t;

endpackage

// File: src/ccrc_byte.sv
// Eight-bit MSB-first CRC update with start-of-message load and nibble padding.
module ccrc_byte
  import ccrc_pkg::*;
(
  input  ccrc_cfg_t           cfg_i,
  input  logic [CRC_W-1:0]    crc_i,
  input  logic [DATA_W-1:0]   data_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic                first_i,
  output logic [CRC_W-1:0]    crc_o
);

  logic [CNT_W-1:0] cnt_norm;
  logic [CNT_W-1:0] cnt_eff;
  logic [CRC_W-1:0] crc_start;

  always_comb begin
    // zero or oversize counts mean a full byte
    if (count_i == '0 || count_i > CNT_W'(DATA_W)) begin
      cnt_norm = CNT_W'(DATA_W);
    end else begin
      cnt_norm = count_i;
    end
    cnt_eff = cnt_norm;
    if (first_i && cfg_i.pad_to_nibble && cnt_norm[1:0] != 2'b00) begin
      cnt_eff = (cnt_norm < CNT_W'(NIBBLE)) ? CNT_W'(NIBBLE) : CNT_W'(DATA_W);
    end
    crc_start = first_i ? cfg_i.init_value : crc_i;
  end

  always_comb begin
    logic [CRC_W-1:0] crc;
    logic             din;
    logic             top;
    crc = crc_start;
    din = 1'b0;
    top = 1'b0;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      if (CNT_W'(i) < cnt_eff) begin
        // leading pad bits read as zero
        din = (CNT_W'(i) < cnt_norm) ? data_i[i] : 1'b0;
        top = |(crc & cfg_i.top_mask);
        crc = {crc[CRC_W-2:0], 1'b0};
        if (din != top) begin
          crc = crc ^ cfg_i.poly;
        end
      end
    end
    crc_o = crc;
  end

endmodule

// File: src/configurable_crc_engine.sv
// Configurable CRC engine: input stage, byte update and result register.
//
// Usage:
//   Input channel (in_*): one transfer per message chunk. in_tdata carries the
//   data byte and its valid bit count, in_tuser marks the first chunk of a
//   message (loads the initial value) and in_tlast the final chunk.
//   Result channel (out_*): one transfer per message, carrying the CRC masked
//   to the programmed degree.
//   Configuration port (cfg_*): APB-style, registers poly (0x0), degree (0x4),
//   initial value (0x8) and nibble padding (0xC). Program only while idle.
// Result path: a last chunk goes from the input register through the byte update
//   into the result register. Throughput: one chunk per cycle while no last chunk
//   is stalled; the eight bit steps of a chunk are done in one pass of the byte
//   update between the input register and the CRC register.
// Reset: clears both pipeline stages, the CRC register and the config
//   registers (degree 16, all others zero).
// Stall: while a result waits, non-last chunks keep flowing; a following last
//   chunk holds in the input stage and in_tready drops until the result moves.
module configurable_crc_engine
  import ccrc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte, [11:8] bit_count, rest zero
  input  logic                   in_tuser,   // [0] first
  input  logic                   in_tlast,
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [CRC_W-1:0]       out_tdata,  // [31:0] crc_value
  // configuration port
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [ADDR_W-1:0]      cfg_paddr,
  input  logic [CRC_W-1:0]       cfg_pwdata,
  output logic [CRC_W-1:0]       cfg_prdata,
  output logic                   cfg_pready
);

  // configuration registers
  logic [CRC_W-1:0] poly_r;
  logic [DEG_W-1:0] degree_r;
  logic [CRC_W-1:0] init_r;
  logic             pad_r;
  reg_idx_t         cfg_idx;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r   <= '0;
      degree_r <= DEGREE_RESET;
      init_r   <= '0;
      pad_r    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_POLY:   poly_r   <= cfg_pwdata;
        REG_DEGREE: degree_r <= cfg_pwdata[DEG_W-1:0];
        REG_INIT:   init_r   <= cfg_pwdata;
        REG_PAD:    pad_r    <= cfg_pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_POLY:   cfg_prdata = poly_r;
      REG_DEGREE: cfg_prdata = CRC_W'(degree_r);
      REG_INIT:   cfg_prdata = init_r;
      REG_PAD:    cfg_prdata = CRC_W'(pad_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // derived configuration: degree zero acts as degree one
  ccrc_cfg_t        cfg;
  logic [DEG_W-1:0] deg_eff;

  always_comb begin
    deg_eff           = (degree_r == '0) ? DEG_W'(1) : degree_r;
    cfg.poly          = poly_r;
    cfg.init_value    = init_r;
    cfg.top_mask      = CRC_W'(1) << (deg_eff - DEG_W'(1));
    cfg.out_mask      = cfg.top_mask | (cfg.top_mask - CRC_W'(1));
    cfg.pad_to_nibble = pad_r;
  end

  // input stage
  logic              s1_v_r;
  logic [DATA_W-1:0] s1_data_r;
  logic [CNT_W-1:0]  s1_cnt_r;
  logic              s1_first_r;
  logic              s1_last_r;
  logic              s1_adv;

  // a last chunk needs a free result register
  assign s1_adv    = s1_v_r & (~s1_last_r | ~out_tvalid | out_tready);
  assign in_tready = ~s1_v_r | s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r  <= in_tdata[DATA_W-1:0];
      s1_cnt_r   <= in_tdata[DATA_W+CNT_W-1:DATA_W];
      s1_first_r <= in_tuser;
      s1_last_r  <= in_tlast;
    end
  end

  // CRC state and result register
  logic [CRC_W-1:0] crc_r;
  logic [CRC_W-1:0] crc_nxt;
  logic             out_valid_r;
  logic [CRC_W-1:0] out_data_r;

  ccrc_byte u_byte (
    .cfg_i   (cfg),
    .crc_i   (crc_r),
    .data_i  (s1_data_r),
    .count_i (s1_cnt_r),
    .first_i (s1_first_r),
    .crc_o   (crc_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
    end else if (s1_adv) begin
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_data_r <= crc_nxt & cfg.out_mask;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_last_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && s1_adv && s1_last_r |=> out_valid_r)
    else $error("last chunk left input stage without a result");

  a_ready_low_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_v_r && s1_last_r && out_tvalid && !out_tready)
    else $error("input stalled without a blocked result");

  a_crc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !s1_adv |=> $stable(crc_r))
    else $error("CRC register moved with no chunk in progress");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && s1_last_r))
    else $error("result appeared without a last chunk");

endmodule
